// ===== sv/nsc_pkg.sv =====
// ---------------------------------------------------------------------------
// nsc_pkg
// Shared types, character codes and helper functions for the NMEA checker.
// ---------------------------------------------------------------------------
package nsc_pkg;

  localparam int LINE_DEPTH_DEF = 128;
  localparam int CharW          = 8;
  localparam int MinLenW        = 7;
  localparam int HdrLen         = 6;

  localparam logic [MinLenW-1:0] MIN_LEN_RESET = 7'd20;

  localparam logic [CharW-1:0] CHAR_NL    = 8'h0A;
  localparam logic [CharW-1:0] CHAR_COMMA = 8'h2C;
  localparam logic [CharW-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CharW-1:0] CHAR_UP_A  = 8'h41;
  localparam logic [CharW-1:0] CHAR_UP_G  = 8'h47;
  localparam logic [CharW-1:0] CHAR_UP_R  = 8'h52;

  typedef enum logic [0:0] {
    OP_CHAR = 1'b0,
    OP_SET  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_GGA   = 2'd1,
    KIND_RMC   = 2'd2
  } kind_t;

  // uppercase hex digit for one nibble
  function automatic logic [CharW-1:0] hex_char(input logic [3:0] nib);
    logic [CharW-1:0] res;
    if (nib <= 4'd9) begin
      res = CharW'(CHAR_ZERO + {4'd0, nib});
    end else begin
      res = CharW'(CHAR_UP_A - 8'd10 + {4'd0, nib});
    end
    return res;
  endfunction

  // "$GPGGA"
  function automatic logic [CharW-1:0] hdr_gga_char(input logic [2:0] idx);
    logic [CharW-1:0] res;
    unique case (idx)
      3'd0:    res = 8'h24;
      3'd1:    res = CHAR_UP_G;
      3'd2:    res = 8'h50;
      3'd3:    res = CHAR_UP_G;
      3'd4:    res = CHAR_UP_G;
      3'd5:    res = CHAR_UP_A;
      default: res = 8'h00;
    endcase
    return res;
  endfunction

  // "$GPRMC"
  function automatic logic [CharW-1:0] hdr_rmc_char(input logic [2:0] idx);
    logic [CharW-1:0] res;
    unique case (idx)
      3'd0:    res = 8'h24;
      3'd1:    res = CHAR_UP_G;
      3'd2:    res = 8'h50;
      3'd3:    res = CHAR_UP_R;
      3'd4:    res = 8'h4D;
      3'd5:    res = 8'h43;
      default: res = 8'h00;
    endcase
    return res;
  endfunction

endpackage

// ===== sv/nsc_if.sv =====
// ---------------------------------------------------------------------------
// nsc channel interfaces
// Valid/ready channels for characters in, verdicts out and the config write.
// ---------------------------------------------------------------------------
interface nsc_in_if;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [nsc_pkg::CharW-1:0]  char_code;
  logic                       set_value;

  modport source (output valid, opcode, char_code, set_value, input ready);
  modport sink   (input valid, opcode, char_code, set_value, output ready);
endinterface

interface nsc_out_if;
  logic        valid;
  logic        ready;
  logic        line_end;
  logic [1:0]  sentence_kind;
  logic        checksum_ok;
  logic        accepted;
  logic        fix_flag;
  logic        dv_flag;

  modport source (output valid, line_end, sentence_kind, checksum_ok, accepted,
                  fix_flag, dv_flag, input ready);
  modport sink   (input valid, line_end, sentence_kind, checksum_ok, accepted,
                  fix_flag, dv_flag, output ready);
endinterface

interface nsc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [nsc_pkg::MinLenW-1:0]   min_length;

  modport source (output valid, min_length, input ready);
  modport sink   (input valid, min_length, output ready);
endinterface

// ===== sv/nmea_sentence_checker.sv =====
// ---------------------------------------------------------------------------
// nmea_sentence_checker
// Per-character NMEA 0183 line checker: header match, XOR checksum, length
// limit, RMC status token and GGA/RMC pairing flags.
// ---------------------------------------------------------------------------
//
//   channel   direction  payload                                  item
//   in_ch     in         opcode, char_code, set_value             one char / flag write
//   out_ch    out        line_end, sentence_kind, checksum_ok,    one verdict per
//                        accepted, fix_flag, dv_flag              input item
//   cfg_ch    in         min_length                               register write
//
// One item per cycle sustained while out_ch is not stalled; each item passes the
// input register, then the result register. The state update is a single pass of
// logic between them. A stalled out_ch holds its result; in_ch keeps taking items
// while the result register can move on. Reset (rst_n low, synchronous) empties both
// stages, clears the line state and sets min_length to 20.
// ---------------------------------------------------------------------------
module nmea_sentence_checker #(
  parameter int LINE_DEPTH = nsc_pkg::LINE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  nsc_in_if.sink    in_ch,
  nsc_out_if.source out_ch,
  nsc_cfg_if.sink   cfg_ch
);
  import nsc_pkg::*;

  // count must hold LINE_DEPTH itself (overlong marker)
  localparam int CntW = $clog2(LINE_DEPTH + 1);
  localparam int CmpW = (CntW > MinLenW) ? CntW : MinLenW;
  localparam logic [CntW-1:0] CNT_LAST = CntW'(LINE_DEPTH - 1);
  localparam logic [CntW-1:0] CNT_FULL = CntW'(LINE_DEPTH);

  // configuration
  logic [MinLenW-1:0] min_len_r;

  // input stage
  logic             in_v_r;
  op_t              in_op_r;
  logic [CharW-1:0] in_char_r;
  logic             in_set_r;

  // line state
  logic [CharW-1:0] recent_r [4];
  logic [CharW-1:0] recent_nxt [4];
  logic [CharW-1:0] xor_r, xor_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             gga_hdr_r, gga_hdr_nxt;
  logic             rmc_hdr_r, rmc_hdr_nxt;
  logic [2:0]       tok_num_r, tok_num_nxt;
  logic [1:0]       tok_chars_r, tok_chars_nxt;
  logic             status_a_r, status_a_nxt;

  // sticky flags
  logic gga_seen_r, gga_seen_nxt;
  logic rmc_seen_r, rmc_seen_nxt;
  logic fix_r, fix_nxt;
  logic valid_flag_r, valid_flag_nxt;

  // result stage
  logic  out_v_r;
  logic  line_end_r, line_end_nxt;
  kind_t kind_r, kind_nxt;
  logic  ok_r, ok_nxt;
  logic  acc_r, acc_nxt;

  logic advance;
  logic take;

  // result register moves when empty or being drained
  assign advance      = !out_v_r || out_ch.ready;
  assign take         = in_v_r && advance;
  assign in_ch.ready  = !in_v_r || advance;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid         = out_v_r;
  assign out_ch.line_end      = line_end_r;
  assign out_ch.sentence_kind = kind_r;
  assign out_ch.checksum_ok   = ok_r;
  assign out_ch.accepted      = acc_r;
  assign out_ch.fix_flag      = fix_r;
  assign out_ch.dv_flag       = valid_flag_r;

  // single pass over one item
  always_comb begin
    logic full;
    logic good;
    logic long_enough;
    logic g;
    logic r;
    for (int i = 0; i < 4; i++) recent_nxt[i] = recent_r[i];
    xor_nxt        = xor_r;
    cnt_nxt        = cnt_r;
    gga_hdr_nxt    = gga_hdr_r;
    rmc_hdr_nxt    = rmc_hdr_r;
    tok_num_nxt    = tok_num_r;
    tok_chars_nxt  = tok_chars_r;
    status_a_nxt   = status_a_r;
    gga_seen_nxt   = gga_seen_r;
    rmc_seen_nxt   = rmc_seen_r;
    fix_nxt        = fix_r;
    valid_flag_nxt = valid_flag_r;
    line_end_nxt   = 1'b0;
    kind_nxt       = KIND_OTHER;
    ok_nxt         = 1'b0;
    acc_nxt        = 1'b0;
    full           = 1'b0;
    good           = 1'b0;
    long_enough    = 1'b0;
    g              = gga_seen_r;
    r              = rmc_seen_r;

    if (in_op_r == OP_SET) begin
      valid_flag_nxt = in_set_r;
    end else if (in_char_r != CHAR_NL) begin
      if (cnt_r >= CNT_LAST) begin
        // overlong: drop the character, mark the line
        cnt_nxt = CNT_FULL;
      end else begin
        if (cnt_r < CntW'(HdrLen)) begin
          if (in_char_r != hdr_gga_char(cnt_r[2:0])) gga_hdr_nxt = 1'b0;
          if (in_char_r != hdr_rmc_char(cnt_r[2:0])) rmc_hdr_nxt = 1'b0;
        end
        // XOR lags four characters behind, skipping the leading '$'
        if (cnt_r >= CntW'(5)) xor_nxt = xor_r ^ recent_r[3];
        recent_nxt[3] = recent_r[2];
        recent_nxt[2] = recent_r[1];
        recent_nxt[1] = recent_r[0];
        recent_nxt[0] = in_char_r;
        cnt_nxt       = cnt_r + CntW'(1);

        // comma tokens, empty ones collapse
        if (in_char_r == CHAR_COMMA) begin
          if (tok_chars_r != 2'd0) begin
            if (tok_num_r != 3'd7) tok_num_nxt = tok_num_r + 3'd1;
            tok_chars_nxt = 2'd0;
          end
        end else begin
          if (tok_num_r == 3'd2) begin
            status_a_nxt = (tok_chars_r == 2'd0) && (in_char_r == CHAR_UP_A);
          end
          if (tok_chars_r != 2'd2) tok_chars_nxt = tok_chars_r + 2'd1;
        end
      end
    end else begin
      // newline: verdict
      line_end_nxt = 1'b1;
      full = (cnt_r >= CntW'(HdrLen)) && (cnt_r < CNT_FULL);
      if (full && gga_hdr_r) begin
        kind_nxt = KIND_GGA;
      end else if (full && rmc_hdr_r) begin
        kind_nxt = KIND_RMC;
      end
      good = (cnt_r < CNT_FULL) &&
             (recent_r[2] == hex_char(xor_r[7:4])) &&
             (recent_r[1] == hex_char(xor_r[3:0]));
      ok_nxt = good;
      long_enough = CmpW'(cnt_r) > CmpW'(min_len_r);
      if (kind_nxt != KIND_OTHER) begin
        if (good && long_enough) begin
          acc_nxt = 1'b1;
          if (kind_nxt == KIND_GGA) g = 1'b1;
          if (kind_nxt == KIND_RMC && !rmc_seen_r) begin
            fix_nxt = status_a_r;
            r       = 1'b1;
          end
          if (g && r) begin
            g              = 1'b0;
            r              = 1'b0;
            valid_flag_nxt = 1'b1;
          end
          gga_seen_nxt = g;
          rmc_seen_nxt = r;
        end else begin
          fix_nxt      = 1'b0;
          gga_seen_nxt = 1'b0;
          rmc_seen_nxt = 1'b0;
        end
      end
      // fresh line
      for (int i = 0; i < 4; i++) recent_nxt[i] = '0;
      xor_nxt       = '0;
      cnt_nxt       = '0;
      gga_hdr_nxt   = 1'b1;
      rmc_hdr_nxt   = 1'b1;
      tok_num_nxt   = '0;
      tok_chars_nxt = '0;
      status_a_nxt  = 1'b0;
    end
  end

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= MIN_LEN_RESET;
    end else if (cfg_ch.valid) begin
      min_len_r <= cfg_ch.min_length;
    end
  end

  // input stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  // input stage payload
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_op_r   <= op_t'(in_ch.opcode);
      in_char_r <= in_ch.char_code;
      in_set_r  <= in_ch.set_value;
    end
  end

  // line state and flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) recent_r[i] <= '0;
      xor_r        <= '0;
      cnt_r        <= '0;
      gga_hdr_r    <= 1'b1;
      rmc_hdr_r    <= 1'b1;
      tok_num_r    <= '0;
      tok_chars_r  <= '0;
      status_a_r   <= 1'b0;
      gga_seen_r   <= 1'b0;
      rmc_seen_r   <= 1'b0;
      fix_r        <= 1'b0;
      valid_flag_r <= 1'b0;
    end else if (take) begin
      for (int i = 0; i < 4; i++) recent_r[i] <= recent_nxt[i];
      xor_r        <= xor_nxt;
      cnt_r        <= cnt_nxt;
      gga_hdr_r    <= gga_hdr_nxt;
      rmc_hdr_r    <= rmc_hdr_nxt;
      tok_num_r    <= tok_num_nxt;
      tok_chars_r  <= tok_chars_nxt;
      status_a_r   <= status_a_nxt;
      gga_seen_r   <= gga_seen_nxt;
      rmc_seen_r   <= rmc_seen_nxt;
      fix_r        <= fix_nxt;
      valid_flag_r <= valid_flag_nxt;
    end
  end

  // result stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= in_v_r;
    end
  end

  // result stage payload
  always_ff @(posedge clk) begin
    if (take) begin
      line_end_r <= line_end_nxt;
      kind_r     <= kind_nxt;
      ok_r       <= ok_nxt;
      acc_r      <= acc_nxt;
    end
  end

endmodule
